FILE: rtl/core/mar_pkg.sv
// ----------------------------------------------------------------------------
// mar_pkg
// Types, constants and the per-region decode function for the mesh asset
// reference parser.
// ----------------------------------------------------------------------------
package mar_pkg;

   localparam logic [31:0] NAME_LIMIT  = 32'd65536;
   localparam logic [31:0] SHAPE_LIMIT = 32'd256;
   localparam logic [31:0] MESH_MAGIC  = 32'h2b024d4d;
   localparam logic [35:0] MID_TRAILER = 36'd36;
   localparam logic [35:0] BOUNDS_SIZE = 36'd24;
   localparam logic [35:0] TAIL_SIZE   = 36'd12;

   localparam logic       CMD_START = 1'b0;
   localparam logic       CMD_BYTE  = 1'b1;
   localparam logic       OUT_NAME  = 1'b0;
   localparam logic       OUT_STAT  = 1'b1;
   localparam logic [1:0] KIND_DISCARD  = 2'd0;
   localparam logic [1:0] KIND_SKELETON = 2'd1;
   localparam logic [1:0] KIND_MATERIAL = 2'd2;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_MAGIC = 4'd1;
   localparam logic [3:0] ST_TRUNC     = 4'd2;
   localparam logic [3:0] ST_NAME_LONG = 4'd3;
   localparam logic [3:0] ST_NOT_TEXT  = 4'd4;
   localparam logic [3:0] ST_SHAPES    = 4'd5;
   localparam logic [3:0] ST_VERTEX    = 4'd6;
   localparam logic [3:0] ST_TRIANGLE  = 4'd7;
   localparam logic [3:0] ST_BLEND     = 4'd8;
   localparam logic [3:0] ST_FOOTER    = 4'd9;
   localparam logic [3:0] ST_TRAILING  = 4'd10;

   typedef enum logic [5:0] {
      PH_IDLE, PH_MAGIC, PH_STAMPS, PH_SKEL_LEN, PH_SKEL_NAME, PH_BOUNDS1,
      PH_REMAPFLAG, PH_AUX_LEN, PH_AUX_NAME, PH_REMAP_CNT, PH_REMAP, PH_BOUNDS2,
      PH_SHAPES, PH_SHAPE_LEN, PH_SHAPE_NAME, PH_MID, PH_MESHES, PH_MESH_LEN,
      PH_MESH_NAME, PH_MAT_LEN, PH_MAT_NAME, PH_MFLAG, PH_TEXSETS, PH_VERTS,
      PH_TRIS, PH_BOUNDS3, PH_VERTDATA, PH_TRIDATA, PH_JOINTS, PH_MORPH, PH_WIDE,
      PH_MORPHDATA, PH_BLENDS, PH_BLENDDATA, PH_RECORDS, PH_REC_LEN, PH_REC_NAME,
      PH_REC_TAIL, PH_FOOTER
   } phase_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [31:0] body_length;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic        ref_type;
      logic [7:0]  ref_byte;
      logic        ref_last;
      logic        ref_bad;
      logic [3:0]  status;
      logic [31:0] fail_offset;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] position;
      logic [31:0] total;
      logic [31:0] accum;
      logic [32:0] left;
      logic [31:0] loop_left;
      logic [31:0] mverts;
      logic [31:0] mtris;
      logic        morph;
      logic        wide;
      logic        nul;
      logic [1:0]  kind;
      logic        finished;
   } st_type;

   typedef struct packed {
      st_type      s;
      logic        go;
      phase_type   nph;
      logic [35:0] need;
      logic        stp;
      logic [3:0]  code;
   } fol_type;

   function automatic logic is_name(phase_type ph);
      return ph == PH_SKEL_NAME || ph == PH_AUX_NAME || ph == PH_SHAPE_NAME ||
             ph == PH_MESH_NAME || ph == PH_MAT_NAME || ph == PH_REC_NAME;
   endfunction

   function automatic fol_type do_stop(fol_type f, logic [3:0] code);
      fol_type r;
      r = f;
      r.go = 1'b0;
      r.stp = 1'b1;
      r.code = code;
      r.s.phase = PH_IDLE;
      r.s.finished = 1'b1;
      r.s.left = '0;
      return r;
   endfunction

   // Decide the region that follows the one just completed.
   function automatic fol_type mar_follow(st_type s, logic [66:0] blend_bytes);
      fol_type     f;
      logic [31:0] v;
      logic [31:0] rem;
      logic [31:0] len;
      logic [37:0] vb;
      logic [34:0] tb;
      f.s = s;
      f.go = 1'b1;
      f.nph = PH_IDLE;
      f.need = '0;
      f.stp = 1'b0;
      f.code = ST_OK;
      v = s.accum;
      rem = s.total - s.position;
      len = {v[7:0], v[15:8], v[23:16], v[31:24]};
      vb = ({6'b0, s.mverts} << 5) + ({6'b0, s.mverts} << 4);
      tb = ({3'b0, s.mtris} << 2) + ({3'b0, s.mtris} << 1);
      if (is_name(s.phase) && s.nul) begin
         f = do_stop(f, ST_NOT_TEXT);
      end else begin
         case (s.phase)
            PH_MAGIC: begin
               if (v != MESH_MAGIC) f = do_stop(f, ST_BAD_MAGIC);
               else begin f.nph = PH_STAMPS; f.need = 36'd8; end
            end
            PH_STAMPS: begin f.nph = PH_SKEL_LEN; f.need = 36'd4; end
            PH_SKEL_LEN, PH_AUX_LEN, PH_SHAPE_LEN, PH_MESH_LEN, PH_MAT_LEN,
            PH_REC_LEN: begin
               if (len > NAME_LIMIT) f = do_stop(f, ST_NAME_LONG);
               else begin
                  f.s.nul = 1'b0;
                  f.need = {4'b0, len};
                  case (s.phase)
                     PH_SKEL_LEN: begin
                        f.s.kind = KIND_SKELETON; f.nph = PH_SKEL_NAME;
                     end
                     PH_AUX_LEN: begin
                        f.s.kind = KIND_DISCARD; f.nph = PH_AUX_NAME;
                     end
                     PH_SHAPE_LEN: begin
                        f.s.kind = KIND_DISCARD; f.nph = PH_SHAPE_NAME;
                     end
                     PH_MESH_LEN: begin
                        f.s.kind = KIND_DISCARD; f.nph = PH_MESH_NAME;
                     end
                     PH_MAT_LEN: begin
                        f.s.kind = KIND_MATERIAL; f.nph = PH_MAT_NAME;
                     end
                     default: begin
                        f.s.kind = KIND_MATERIAL; f.nph = PH_REC_NAME;
                     end
                  endcase
               end
            end
            PH_SKEL_NAME: begin f.nph = PH_BOUNDS1; f.need = BOUNDS_SIZE; end
            PH_BOUNDS1: begin f.nph = PH_REMAPFLAG; f.need = 36'd1; end
            PH_REMAPFLAG: begin f.nph = PH_AUX_LEN; f.need = 36'd4; end
            PH_AUX_NAME: begin f.nph = PH_REMAP_CNT; f.need = 36'd2; end
            PH_REMAP_CNT: begin f.nph = PH_REMAP; f.need = {20'b0, v[15:0]}; end
            PH_REMAP: begin f.nph = PH_BOUNDS2; f.need = BOUNDS_SIZE; end
            PH_BOUNDS2: begin f.nph = PH_SHAPES; f.need = 36'd4; end
            PH_SHAPES: begin
               if (v > SHAPE_LIMIT) f = do_stop(f, ST_SHAPES);
               else begin
                  f.s.loop_left = v;
                  if (v != '0) begin f.nph = PH_SHAPE_LEN; f.need = 36'd4; end
                  else begin f.nph = PH_MID; f.need = MID_TRAILER; end
               end
            end
            PH_SHAPE_NAME: begin
               f.s.loop_left = s.loop_left - 32'd1;
               if (f.s.loop_left != '0) begin f.nph = PH_SHAPE_LEN; f.need = 36'd4; end
               else begin f.nph = PH_MID; f.need = MID_TRAILER; end
            end
            PH_MID: begin f.nph = PH_MESHES; f.need = 36'd4; end
            PH_MESHES: begin
               f.s.loop_left = v;
               if (v != '0) begin f.nph = PH_MESH_LEN; f.need = 36'd4; end
               else begin f.nph = PH_RECORDS; f.need = 36'd4; end
            end
            PH_MESH_NAME: begin f.nph = PH_MAT_LEN; f.need = 36'd4; end
            PH_MAT_NAME: begin f.nph = PH_MFLAG; f.need = 36'd1; end
            PH_MFLAG: begin f.nph = PH_TEXSETS; f.need = 36'd4; end
            PH_TEXSETS: begin f.nph = PH_VERTS; f.need = 36'd4; end
            PH_VERTS: begin
               f.s.mverts = v; f.nph = PH_TRIS; f.need = 36'd4;
            end
            PH_TRIS: begin
               f.s.mtris = v;
               if (vb > {6'b0, rem}) f = do_stop(f, ST_VERTEX);
               else begin f.nph = PH_BOUNDS3; f.need = BOUNDS_SIZE; end
            end
            PH_BOUNDS3: begin f.nph = PH_VERTDATA; f.need = vb[35:0]; end
            PH_VERTDATA: begin
               if (tb > {3'b0, rem}) f = do_stop(f, ST_TRIANGLE);
               else begin f.nph = PH_TRIDATA; f.need = {1'b0, tb}; end
            end
            PH_TRIDATA: begin f.nph = PH_JOINTS; f.need = TAIL_SIZE; end
            PH_JOINTS: begin f.nph = PH_MORPH; f.need = 36'd1; end
            PH_MORPH: begin
               f.s.morph = v[7:0] != 8'd0;
               if (f.s.morph) begin f.nph = PH_WIDE; f.need = 36'd1; end
               else begin f.nph = PH_BLENDS; f.need = 36'd4; end
            end
            PH_WIDE: begin
               f.s.wide = v[7:0] != 8'd0;
               f.nph = PH_MORPHDATA;
               f.need = f.s.wide ? {1'b0, s.mverts, 3'b0} : {2'b0, s.mverts, 2'b0};
            end
            PH_MORPHDATA: begin f.nph = PH_BLENDS; f.need = 36'd4; end
            PH_BLENDS, PH_BLENDDATA: begin
               if (s.phase == PH_BLENDS && v != '0 && !s.morph) begin
                  if (blend_bytes > {35'b0, rem}) f = do_stop(f, ST_BLEND);
                  else begin f.nph = PH_BLENDDATA; f.need = blend_bytes[35:0]; end
               end else begin
                  f.s.loop_left = s.loop_left - 32'd1;
                  f.need = 36'd4;
                  f.nph = (f.s.loop_left != '0) ? PH_MESH_LEN : PH_RECORDS;
               end
            end
            PH_RECORDS: begin
               f.s.loop_left = v;
               f.need = 36'd4;
               f.nph = (v != '0) ? PH_REC_LEN : PH_FOOTER;
            end
            PH_REC_NAME: begin f.nph = PH_REC_TAIL; f.need = TAIL_SIZE; end
            PH_REC_TAIL: begin
               f.s.loop_left = s.loop_left - 32'd1;
               f.need = 36'd4;
               f.nph = (f.s.loop_left != '0) ? PH_REC_LEN : PH_FOOTER;
            end
            PH_FOOTER: begin
               if (v != MESH_MAGIC) f = do_stop(f, ST_FOOTER);
               else if (s.position == s.total) f = do_stop(f, ST_OK);
               else f = do_stop(f, ST_TRAILING);
            end
            default: f = do_stop(f, ST_TRUNC);
         endcase
      end
      return f;
   endfunction

endpackage

FILE: rtl/core/mar_step.sv
// ----------------------------------------------------------------------------
// mar_step
// Next-state and result logic for one accepted item.
// ----------------------------------------------------------------------------
module mar_step import mar_pkg::*; (
   input  st_type     cur,
   input  req_type    item,
   output st_type     nxt,
   output rsp_type    res0,
   output rsp_type    res1,
   output logic [1:0] n_res
);

   st_type      s;
   fol_type     f;
   logic [31:0] accum_new;
   logic [63:0] prod;
   logic [66:0] blend_bytes;
   logic        active;
   phase_type   ph;
   logic [35:0] need;
   logic [31:0] rem;
   logic        stp;
   logic [3:0]  code;
   logic        name_out;
   logic        last;
   rsp_type     name_r;
   rsp_type     stat_r;

   assign accum_new   = {cur.accum[23:0], item.data_byte};
   assign prod        = accum_new * cur.mverts;
   // the blend byte count wraps at 64 bits
   assign blend_bytes = {3'b0, prod[60:0], 3'b0};

   always_comb begin
      s = cur;
      f = '0;
      active = 1'b0;
      ph = PH_IDLE;
      need = '0;
      rem = '0;
      stp = 1'b0;
      code = ST_OK;
      name_out = 1'b0;
      last = 1'b0;
      if (item.cmd == CMD_START) begin
         s = '0;
         s.phase = PH_IDLE;
         s.total = item.body_length;
         active = 1'b1;
         ph = PH_MAGIC;
         need = 36'd4;
      end else if (!(cur.finished || cur.phase == PH_IDLE || cur.left == '0)) begin
         s.position = cur.position + 32'd1;
         s.accum = accum_new;
         s.left = cur.left - 33'd1;
         if (is_name(cur.phase)) begin
            last = s.left == '0;
            if (item.data_byte == 8'd0) s.nul = 1'b1;
            name_out = cur.kind != KIND_DISCARD;
         end
         if (s.left == '0) begin
            f = mar_follow(s, blend_bytes);
            s = f.s;
            stp = f.stp;
            code = f.code;
            active = f.go;
            ph = f.nph;
            need = f.need;
         end
      end
      // Walk through empty regions.
      for (int i = 0; i < 4; i++) begin
         if (active) begin
            rem = s.total - s.position;
            if (need > {4'b0, rem}) begin
               s.phase = PH_IDLE;
               s.finished = 1'b1;
               s.left = '0;
               stp = 1'b1;
               code = ST_TRUNC;
               active = 1'b0;
            end else begin
               s.phase = ph;
               s.accum = '0;
               s.left = need[32:0];
               if (need != '0) begin
                  active = 1'b0;
               end else begin
                  f = mar_follow(s, blend_bytes);
                  s = f.s;
                  stp = f.stp;
                  code = f.code;
                  active = f.go;
                  ph = f.nph;
                  need = f.need;
               end
            end
         end
      end
      nxt = s;
   end

   always_comb begin
      name_r = '0;
      name_r.out_kind = OUT_NAME;
      name_r.ref_type = cur.kind == KIND_MATERIAL;
      name_r.ref_byte = item.data_byte;
      name_r.ref_last = last;
      name_r.ref_bad  = last && (cur.nul || item.data_byte == 8'd0);
      stat_r = '0;
      stat_r.out_kind = OUT_STAT;
      stat_r.status = code;
      stat_r.fail_offset = s.position;
      res0 = name_out ? name_r : stat_r;
      res1 = stat_r;
      n_res = {1'b0, name_out} + {1'b0, stp};
   end

endmodule

FILE: rtl/core/mar_fifo.sv
// ----------------------------------------------------------------------------
// mar_fifo
// Four-entry result queue taking up to two items a cycle.
// ----------------------------------------------------------------------------
module mar_fifo import mar_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  rsp_type    d0,
   input  rsp_type    d1,
   input  logic       pop,
   output rsp_type    q,
   output logic [2:0] count
);

   rsp_type    mem [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      wp_in = wp_ff + push_n;
      rp_in = rp_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_n} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem[wp_ff] <= d0;
      if (push_n == 2'd2) mem[wp_ff + 2'd1] <= d1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         count_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         count_ff <= count_in;
      end
   end

   assign q = mem[rp_ff];
   assign count = count_ff;

endmodule

FILE: rtl/core/mesh_asset_reference_parser.sv
// ----------------------------------------------------------------------------
// mesh_asset_reference_parser
// Streaming parser that extracts skeleton and material names from a mesh body.
// ----------------------------------------------------------------------------
// Each item is captured in an input register, decoded by one pass of logic and
// its results (a name byte, a status, or both) go into a four-entry result
// queue, so a byte stream runs at one byte per clock while the queue has room.
// The input register holds its item, whatever it yields, while the queue has
// fewer than two free slots; the output drains one result per clock when not stalled.
module mesh_asset_reference_parser import mar_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff, in_data_in;
   st_type     st_ff, st_in, st_nxt, st_rst;
   rsp_type    res0, res1;
   logic [1:0] n_res, push_n;
   logic [2:0] count;
   logic       proceed, accept, pop;

   assign proceed   = in_valid_ff && count <= 3'd2;
   assign req_stall = in_valid_ff && !proceed;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count != 3'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = proceed ? n_res : 2'd0;

   mar_step u_step (
      .cur   (st_ff),
      .item  (in_data_ff),
      .nxt   (st_nxt),
      .res0  (res0),
      .res1  (res1),
      .n_res (n_res)
   );

   mar_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_n (push_n),
      .d0     (res0),
      .d1     (res1),
      .pop    (pop),
      .q      (rsp_data),
      .count  (count)
   );

   always_comb begin
      in_valid_in = accept ? 1'b1 : (proceed ? 1'b0 : in_valid_ff);
      in_data_in  = accept ? req_data : in_data_ff;
      st_in       = proceed ? st_nxt : st_ff;
      st_rst          = '0;
      st_rst.phase    = PH_IDLE;
      st_rst.finished = 1'b1;
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff <= st_rst;
      end else begin
         in_valid_ff <= in_valid_in;
         st_ff <= st_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= 3'd4) else $error("result queue overfilled");

   a_two_then_status: assert property (@(posedge clock) disable iff (reset)
      (proceed && n_res == 2'd2) |-> (res0.out_kind == OUT_NAME &&
      res1.out_kind == OUT_STAT)) else $error("double result is not name then status");

   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      (proceed && st_ff.finished && in_data_ff.cmd == CMD_BYTE) |-> n_res == 2'd0)
      else $error("result from a finished parse");

   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      (proceed && n_res != 2'd0 && res1.out_kind == OUT_STAT &&
      (n_res == 2'd2 || res0.out_kind == OUT_STAT)) |=> st_ff.finished)
      else $error("status sent but parse not finished");

endmodule
